[src/fct_pkg.sv]
package fct_pkg;

  localparam int unsigned TEMP_W = 12;
  localparam int unsigned CMP_W = 13;
  localparam int unsigned SET_W = 9;
  localparam int unsigned HOLD_W = 4;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  typedef logic signed [CMP_W-1:0] cmp_t;

  localparam cmp_t FROST_ON_TEMP = 13'sd50;
  localparam cmp_t FROST_OFF_TEMP = 13'sd70;
  localparam cmp_t HYST_BAND = 13'sd10;
  localparam cmp_t HIGH_BAND = 13'sd30;
  localparam logic [HOLD_W-1:0] STARTUP_HOLD_SECONDS = 4'd10;

  typedef enum logic [2:0] {
    REG_POWER_ON     = 3'd0,
    REG_MODE         = 3'd1,
    REG_FAN_SETTING  = 3'd2,
    REG_VENT_SPEED   = 3'd3,
    REG_SET_TEMP     = 3'd4,
    REG_FROST_ENABLE = 3'd5,
    REG_AUTO_STOP    = 3'd6
  } reg_idx_t;

  localparam logic [1:0] MODE_COOL = 2'd0;
  localparam logic [1:0] MODE_HEAT = 2'd1;
  localparam logic [1:0] MODE_VENT = 2'd2;

  localparam logic [1:0] FAN_OFF = 2'd0;
  localparam logic [1:0] FAN_LOW = 2'd1;
  localparam logic [1:0] FAN_MID = 2'd2;
  localparam logic [1:0] FAN_AUTO = 2'd3;

  localparam logic [1:0] LEVEL_LOW = 2'd0;
  localparam logic [1:0] LEVEL_MID = 2'd1;
  localparam logic [1:0] LEVEL_HIGH = 2'd2;
  localparam logic [1:0] VENT_SPEED_MAX = 2'd2;

endpackage

[src/fan_coil_thermostat_control.sv]
// The result of an accepted item is registered and shows on the output in the next cycle.
// Throughput: one item per cycle; the controller state registers double as the
// result register, and the next item is taken in the cycle the result is taken.
// Reset (synchronous, active high) loads the register defaults, clears all relay
// state and starts the start-up hold, which forces fan and valve off for the
// results of the first nine items.
module fan_coil_thermostat_control (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fct_pkg::APB_AW-1:0]    paddr,
  input  logic [fct_pkg::APB_DW-1:0]    pwdata,
  output logic [fct_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [fct_pkg::TEMP_W-1:0] air_temp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    fan_speed,
  output logic                          valve_open,
  output logic [1:0]                    auto_fan_level,
  output logic                          startup_holding
);
  import fct_pkg::*;

  // Configuration registers.
  logic             power_on;
  logic [1:0]       mode;
  logic [1:0]       fan_setting;
  logic [1:0]       vent_speed;
  logic [SET_W-1:0] setpoint;
  logic             frost_protect_enable;
  logic             auto_fan_stop;

  // Controller state.
  logic [HOLD_W-1:0] hold_count, hold_count_next;
  logic              frost_latched, frost_latched_next;
  logic              cool_running, cool_running_next;
  logic              heat_running, heat_running_next;
  logic [1:0]        fan_drive, fan_drive_next;
  logic              valve_drive, valve_drive_next;
  logic [1:0]        auto_level, auto_level_next;

  logic       cfg_write;
  reg_idx_t   cfg_idx;
  logic       accept;
  cmp_t       temp;
  cmp_t       setp;
  logic [1:0] cool_level;
  logic [1:0] heat_level;
  logic       sat_fan_stop;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      power_on <= 1'b1;
      mode <= MODE_VENT;
      fan_setting <= FAN_AUTO;
      vent_speed <= LEVEL_LOW;
      setpoint <= 9'd200;
      frost_protect_enable <= 1'b1;
      auto_fan_stop <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_POWER_ON:     power_on <= pwdata[0];
        REG_MODE:         mode <= pwdata[1:0];
        REG_FAN_SETTING:  fan_setting <= pwdata[1:0];
        REG_VENT_SPEED:   vent_speed <= pwdata[1:0];
        REG_SET_TEMP:     setpoint <= pwdata[SET_W-1:0];
        REG_FROST_ENABLE: frost_protect_enable <= pwdata[0];
        REG_AUTO_STOP:    auto_fan_stop <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_POWER_ON:     prdata = APB_DW'(power_on);
      REG_MODE:         prdata = APB_DW'(mode);
      REG_FAN_SETTING:  prdata = APB_DW'(fan_setting);
      REG_VENT_SPEED:   prdata = APB_DW'(vent_speed);
      REG_SET_TEMP:     prdata = APB_DW'(setpoint);
      REG_FROST_ENABLE: prdata = APB_DW'(frost_protect_enable);
      REG_AUTO_STOP:    prdata = APB_DW'(auto_fan_stop);
      default:          prdata = '0;
    endcase
  end

  // The state registers hold the result, so they may only move once the
  // previous result has been taken.
  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  assign temp = {air_temp[TEMP_W-1], air_temp};
  assign setp = {{(CMP_W-SET_W){1'b0}}, setpoint};

  always_comb begin
    if (temp > setp + HIGH_BAND) begin
      cool_level = LEVEL_HIGH;
    end else if (temp >= setp + HYST_BAND) begin
      cool_level = LEVEL_MID;
    end else begin
      cool_level = LEVEL_LOW;
    end
    if (temp < setp - HIGH_BAND) begin
      heat_level = LEVEL_HIGH;
    end else if (temp <= setp - HYST_BAND) begin
      heat_level = LEVEL_MID;
    end else begin
      heat_level = LEVEL_LOW;
    end
  end

  assign sat_fan_stop = auto_fan_stop;

  always_comb begin
    logic       demand;
    logic       idle;
    logic [1:0] lvl;

    hold_count_next = hold_count;
    frost_latched_next = frost_latched;
    cool_running_next = cool_running;
    heat_running_next = heat_running;
    fan_drive_next = fan_drive;
    valve_drive_next = valve_drive;
    auto_level_next = auto_level;
    demand = 1'b0;
    idle = 1'b0;
    lvl = LEVEL_LOW;

    if (hold_count != '0) begin
      hold_count_next = hold_count - 1'b1;
    end

    if (hold_count_next != '0) begin
      fan_drive_next = FAN_OFF;
      valve_drive_next = 1'b0;
    end else if (!power_on) begin
      if (!frost_protect_enable) begin
        fan_drive_next = FAN_OFF;
        valve_drive_next = 1'b0;
        frost_latched_next = 1'b0;
      end else if (temp <= FROST_ON_TEMP) begin
        frost_latched_next = 1'b1;
        valve_drive_next = 1'b1;
        fan_drive_next = FAN_MID;
      end else if (frost_latched && temp >= FROST_OFF_TEMP) begin
        fan_drive_next = FAN_OFF;
        valve_drive_next = 1'b0;
        frost_latched_next = 1'b0;
      end else if (!frost_latched) begin
        fan_drive_next = FAN_OFF;
        valve_drive_next = 1'b0;
      end
    end else begin
      frost_latched_next = 1'b0;
      case (mode)
        MODE_COOL: begin
          heat_running_next = 1'b0;
          lvl = cool_level;
          if (temp <= setp - HYST_BAND) begin
            idle = 1'b1;
            cool_running_next = 1'b0;
          end else if (temp < setp + HYST_BAND) begin
            demand = cool_running;
            idle = !cool_running;
          end else begin
            demand = 1'b1;
            cool_running_next = 1'b1;
          end
        end
        MODE_HEAT: begin
          cool_running_next = 1'b0;
          lvl = heat_level;
          if (temp >= setp + HYST_BAND) begin
            idle = 1'b1;
            heat_running_next = 1'b0;
          end else if (temp > setp - HYST_BAND) begin
            demand = heat_running;
            idle = !heat_running;
          end else begin
            demand = 1'b1;
            heat_running_next = 1'b1;
          end
        end
        MODE_VENT: begin
          cool_running_next = 1'b0;
          heat_running_next = 1'b0;
          valve_drive_next = 1'b0;
          if (vent_speed <= VENT_SPEED_MAX) begin
            fan_drive_next = vent_speed + 2'd1;
          end
        end
        default: ;
      endcase

      // Target reached: valve shut, fan off or at low in auto when told to run.
      if (idle) begin
        valve_drive_next = 1'b0;
        if (fan_setting == FAN_AUTO) begin
          fan_drive_next = sat_fan_stop ? FAN_OFF : FAN_LOW;
          auto_level_next = LEVEL_LOW;
        end else begin
          fan_drive_next = FAN_OFF;
        end
      end
      if (demand) begin
        valve_drive_next = 1'b1;
        if (fan_setting == FAN_AUTO) begin
          auto_level_next = lvl;
          fan_drive_next = lvl + 2'd1;
        end else begin
          fan_drive_next = fan_setting + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= STARTUP_HOLD_SECONDS;
      frost_latched <= 1'b0;
      cool_running <= 1'b0;
      heat_running <= 1'b0;
      fan_drive <= FAN_OFF;
      valve_drive <= 1'b0;
      auto_level <= LEVEL_LOW;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        hold_count <= hold_count_next;
        frost_latched <= frost_latched_next;
        cool_running <= cool_running_next;
        heat_running <= heat_running_next;
        fan_drive <= fan_drive_next;
        valve_drive <= valve_drive_next;
        auto_level <= auto_level_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign fan_speed = fan_drive;
  assign valve_open = valve_drive;
  assign auto_fan_level = auto_level;
  assign startup_holding = (hold_count != '0);

  // While the start-up hold is active every relay must be off.
  a_hold_forces_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && startup_holding |-> fan_speed == FAN_OFF && !valve_open)
    else $error("relay driven during start-up hold");

  // An accepted item always produces a result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // The hold count only ever runs down.
  a_hold_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hold_count <= $past(hold_count))
    else $error("start-up hold count increased");

  // Frost latch can only be set while the unit is switched off.
  a_frost_only_off: assert property (@(posedge clk) disable iff (rst)
    accept && power_on |=> !frost_latched)
    else $error("frost latch set while powered on");

endmodule

[tb/fan_coil_thermostat_control_test.sv]
module fan_coil_thermostat_control_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fct_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 40;
  localparam int ITEMS_PER_PHASE = 38;

  // Test names for codes: the high fan setting, which the package calls FAN_MID,
  // and the codes with no meaning for mode and ventilate speed.
  localparam logic [1:0] FAN_SET_HIGH = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] VENT_SPEED_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] fan;
    logic       valve;
    logic [1:0] level;
    logic       holding;
  } relay_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_AW-1:0]        paddr;
  logic [APB_DW-1:0]        pwdata;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [TEMP_W-1:0] air_temp;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               fan_speed;
  logic                     valve_open;
  logic [1:0]               auto_fan_level;
  logic                     startup_holding;

  fan_coil_thermostat_control dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .air_temp        (air_temp),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .fan_speed       (fan_speed),
    .valve_open      (valve_open),
    .auto_fan_level  (auto_fan_level),
    .startup_holding (startup_holding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register mirror, kept at the reset values until written.
  logic             cfg_power = 1'b1;
  logic [1:0]       cfg_mode = MODE_VENT;
  logic [1:0]       cfg_fan = FAN_AUTO;
  logic [1:0]       cfg_vent = LEVEL_LOW;
  logic [SET_W-1:0] cfg_setpoint = 9'd200;
  logic             cfg_frost_en = 1'b1;
  logic             cfg_auto_stop = 1'b1;

  // Controller state as it should be after each accepted item.
  logic [HOLD_W-1:0] hold_left = STARTUP_HOLD_SECONDS;
  logic              frost_on = 1'b0;
  logic              cool_call = 1'b0;
  logic              heat_call = 1'b0;
  logic [1:0]        fan_q = FAN_OFF;
  logic              valve_q = 1'b0;
  logic [1:0]        level_q = LEVEL_LOW;

  relay_t pending[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  bit     gaps_on = 1'b1;
  bit     stalls_on = 1'b1;
  int     sink_hold = 0;

  function automatic void relays_off();
    fan_q = FAN_OFF;
    valve_q = 1'b0;
  endfunction

  // Room has reached the target: valve shut, fan stopped or kept low in auto.
  function automatic void demand_met();
    if (cfg_fan == FAN_AUTO) begin
      fan_q = cfg_auto_stop ? FAN_OFF : FAN_LOW;
      level_q = LEVEL_LOW;
    end else begin
      fan_q = FAN_OFF;
    end
    valve_q = 1'b0;
  endfunction

  function automatic void demand_on(input int t, input int sp, input bit cooling);
    logic [1:0] lvl;
    if (cfg_fan != FAN_AUTO) begin
      fan_q = cfg_fan + 2'd1;
      valve_q = 1'b1;
    end else begin
      if (cooling) begin
        if (t > sp + HIGH_BAND) lvl = LEVEL_HIGH;
        else if (t >= sp + HYST_BAND) lvl = LEVEL_MID;
        else lvl = LEVEL_LOW;
      end else begin
        if (t < sp - HIGH_BAND) lvl = LEVEL_HIGH;
        else if (t <= sp - HYST_BAND) lvl = LEVEL_MID;
        else lvl = LEVEL_LOW;
      end
      level_q = lvl;
      fan_q = lvl + 2'd1;
      valve_q = 1'b1;
    end
  endfunction

  function automatic relay_t thermostat_tick(input logic signed [TEMP_W-1:0] temp);
    int     t;
    int     sp;
    relay_t r;
    t = temp;
    sp = cfg_setpoint;
    if (hold_left != 0) hold_left = hold_left - 1'b1;
    if (hold_left != 0) begin
      relays_off();
    end else if (!cfg_power) begin
      // Frost protection latches at or below the low limit and lets go at or above
      // the higher one; in between a latched unit keeps its relays as they are.
      if (!cfg_frost_en) begin
        relays_off();
        frost_on = 1'b0;
      end else if (t <= FROST_ON_TEMP) begin
        frost_on = 1'b1;
        valve_q = 1'b1;
        fan_q = FAN_MID;
      end else if (frost_on && t >= FROST_OFF_TEMP) begin
        relays_off();
        frost_on = 1'b0;
      end else if (!frost_on) begin
        relays_off();
      end
    end else begin
      frost_on = 1'b0;
      case (cfg_mode)
        MODE_COOL: begin
          heat_call = 1'b0;
          if (t <= sp - HYST_BAND) begin
            demand_met();
            cool_call = 1'b0;
          end else if (t < sp + HYST_BAND) begin
            if (cool_call) demand_on(t, sp, 1'b1);
            else demand_met();
          end else begin
            demand_on(t, sp, 1'b1);
            cool_call = 1'b1;
          end
        end
        MODE_HEAT: begin
          cool_call = 1'b0;
          if (t >= sp + HYST_BAND) begin
            demand_met();
            heat_call = 1'b0;
          end else if (t > sp - HYST_BAND) begin
            if (heat_call) demand_on(t, sp, 1'b0);
            else demand_met();
          end else begin
            demand_on(t, sp, 1'b0);
            heat_call = 1'b1;
          end
        end
        MODE_VENT: begin
          cool_call = 1'b0;
          heat_call = 1'b0;
          valve_q = 1'b0;
          if (cfg_vent <= VENT_SPEED_MAX) fan_q = cfg_vent + 2'd1;
        end
        default: ;
      endcase
    end
    r.fan = fan_q;
    r.valve = valve_q;
    r.level = level_q;
    r.holding = (hold_left != 0);
    return r;
  endfunction

  // Results are checked before the item of the same edge is predicted, so
  // the oldest expectation always belongs to the result on the output.
  always @(posedge clk) begin
    relay_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $display("%0t: result with no item pending: fan %0d valve %0d level %0d hold %0d",
                 $time, fan_speed, valve_open, auto_fan_level, startup_holding);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (fan_speed !== want.fan) begin
          $display("%0t: fan_speed expected %0d actual %0d", $time, want.fan, fan_speed);
          mismatches++;
        end
        if (valve_open !== want.valve) begin
          $display("%0t: valve_open expected %0d actual %0d", $time, want.valve, valve_open);
          mismatches++;
        end
        if (auto_fan_level !== want.level) begin
          $display("%0t: auto_fan_level expected %0d actual %0d",
                   $time, want.level, auto_fan_level);
          mismatches++;
        end
        if (startup_holding !== want.holding) begin
          $display("%0t: startup_holding expected %0d actual %0d",
                   $time, want.holding, startup_holding);
          mismatches++;
        end
      end
    end
    if (!rst && in_valid && in_ready) pending.push_back(thermostat_tick(air_temp));
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("fan_coil_thermostat_control regression: fail");
    $finish;
  end

  // Result side: a random stall before each result while stalls are on, or a
  // long hold-off when a test asks for one.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = stalls_on ? $urandom_range(0, 10) : 0;
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      @(negedge clk);
    end
  end

  task automatic send_temp(input int temp);
    int gap;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    air_temp <= temp[TEMP_W-1:0];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    drain_results();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_POWER_ON:     cfg_power = value[0];
      REG_MODE:         cfg_mode = value[1:0];
      REG_FAN_SETTING:  cfg_fan = value[1:0];
      REG_VENT_SPEED:   cfg_vent = value[1:0];
      REG_SET_TEMP:     cfg_setpoint = value[SET_W-1:0];
      REG_FROST_ENABLE: cfg_frost_en = value[0];
      REG_AUTO_STOP:    cfg_auto_stop = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Temperature drifts around a base point so the hysteresis bands are
  // crossed in both directions, with jumps and the odd wild reading.
  task automatic send_walk(input int count, input int base);
    int t;
    int r;
    t = base + $urandom_range(0, 80) - 40;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 5) t = $urandom_range(0, 4095) - 2048;
      else if (r < 12) t = base + $urandom_range(0, 120) - 60;
      else t = t + $urandom_range(0, 24) - 12;
      if (t > 2047) t = 2047;
      if (t < -2048) t = -2048;
      send_temp(t);
    end
  endtask

  task automatic test_startup_hold();
    send_temp(-2048);
    send_temp(2047);
    send_temp(-400);
    send_temp(1250);
    send_temp(0);
    send_temp(-1);
    send_temp(1365);
    send_temp(-1366);
    send_temp(200);
    send_temp(50);
  endtask

  task automatic test_frost_protection();
    write_reg(REG_POWER_ON, 32'd0);
    send_temp(100);
    send_temp(50);
    send_temp(60);
    send_temp(70);
    send_temp(49);
    write_reg(REG_FROST_ENABLE, 32'd0);
    send_temp(40);
    write_reg(REG_FROST_ENABLE, 32'd1);
    send_temp(60);
  endtask

  task automatic test_hysteresis_bands();
    write_reg(REG_POWER_ON, 32'd1);
    write_reg(REG_MODE, APB_DW'(MODE_COOL));
    write_reg(REG_FAN_SETTING, APB_DW'(FAN_AUTO));
    write_reg(REG_SET_TEMP, 32'd200);
    send_temp(209);
    send_temp(210);
    send_temp(231);
    send_temp(205);
    send_temp(190);
    write_reg(REG_MODE, APB_DW'(MODE_HEAT));
    write_reg(REG_FAN_SETTING, APB_DW'(FAN_SET_HIGH));
    write_reg(REG_AUTO_STOP, 32'd0);
    send_temp(190);
    send_temp(209);
    send_temp(210);
  endtask

  task automatic test_ventilate_and_unused_codes();
    write_reg(REG_MODE, APB_DW'(MODE_VENT));
    write_reg(REG_VENT_SPEED, APB_DW'(LEVEL_HIGH));
    send_temp(300);
    write_reg(REG_VENT_SPEED, APB_DW'(VENT_SPEED_UNUSED));
    send_temp(-300);
    write_reg(REG_MODE, APB_DW'(MODE_UNUSED));
    send_temp(20);
  endtask

  task automatic test_random_operation();
    int sp;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 8)
        0: sp = 0;
        1: sp = 511;
        2: sp = 50;
        3: sp = 300;
        4: sp = $urandom_range(0, 511);
        default: sp = $urandom_range(50, 300);
      endcase
      write_reg(REG_POWER_ON, APB_DW'($urandom_range(0, 3) != 0));
      write_reg(REG_MODE, ($urandom_range(0, 9) == 0) ? MODE_UNUSED : $urandom_range(0, 2));
      write_reg(REG_FAN_SETTING, $urandom_range(0, 3));
      write_reg(REG_VENT_SPEED, ($urandom_range(0, 7) == 0) ? VENT_SPEED_UNUSED
                                                              : $urandom_range(0, 2));
      write_reg(REG_SET_TEMP, sp);
      write_reg(REG_FROST_ENABLE, $urandom_range(0, 1));
      write_reg(REG_AUTO_STOP, $urandom_range(0, 1));
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      send_walk(ITEMS_PER_PHASE, cfg_power ? sp : 60);
    end
  endtask

  // The result side holds off while items keep coming back to back, so the
  // block fills and has to stall its input.
  task automatic test_output_backpressure();
    drain_results();
    gaps_on = 1'b0;
    stalls_on = 1'b1;
    sink_hold = 80;
    send_walk(40, cfg_setpoint);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    air_temp = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_startup_hold();
    test_frost_protection();
    test_hysteresis_bands();
    test_ventilate_and_unused_codes();
    test_random_operation();
    test_output_backpressure();

    drain_results();
    repeat (3) @(posedge clk);
    if (mismatches == 0) begin
      $display("fan_coil_thermostat_control regression: pass");
    end else begin
      $display("fan_coil_thermostat_control regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/fct_pkg.sv
src/fan_coil_thermostat_control.sv
tb/fan_coil_thermostat_control_test.sv
